@@ hdl/sff_pkg.sv @@
// Shared types and constants for the smallest factor sieve factorizer.
`default_nettype none
package sff_pkg;

	localparam int TABLE_SIZE = 4096;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int VAL_W      = 12;
	localparam int EXP_W      = 4;
	localparam int DC_W       = 6;
	localparam int ST_W       = 2;
	localparam int MAX_PRIMES = 7;
	localparam int CNT_W      = 3;
	localparam int SQ_W       = 2 * VAL_W;

	localparam logic CMD_BUILD  = 1'b0;
	localparam logic CMD_FACTOR = 1'b1;

	localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
	localparam logic [ST_W-1:0] STAT_RANGE    = 2'd1;
	localparam logic [ST_W-1:0] STAT_NOTBUILT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_SV_RD,
		ST_SV_CHK,
		ST_IN_RD,
		ST_IN_CHK,
		ST_FZ_RD,
		ST_FZ_CHK,
		ST_FZ_DIV,
		ST_DC,
		ST_EMIT
	} sff_state_t;

	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic i_wr;
		logic i_next;
		logic in_start;
		logic j_wr;
		logic j_next;
		logic rd_j;
		logic rd_x;
		logic fz_take;
		logic x_load;
		logic build_done;
		logic dc_step;
		logic emit_step;
	} sff_cmd_t;

	typedef struct packed {
		logic in_build;
		logic in_simple;
		logic lim_small;
		logic clr_last;
		logic rd_zero;
		logic sq_in;
		logic i_last;
		logic j_over;
		logic fz_stop;
		logic div_done;
		logic x_more;
		logic k_last;
		logic out_free;
	} sff_stat_t;

endpackage
`default_nettype wire

@@ hdl/smallest_factor_sieve_factorizer_core.sv @@
// Top level of the smallest prime factor sieve and factorizer.
`default_nettype none
// One transaction at a time. A build clears entries 2..limit at one a cycle, then
// walks the sieve on the single table RAM, each registered table read followed by
// the conditional write. A factorization does a table lookup and a bit-serial
// division for each prime factor counted with multiplicity, a divisor count step
// per distinct prime and an output step per result. Errors, value one and queries
// before a build answer without any table lookup. The result register lets the last
// result wait while the next transaction is accepted. sieve_limit takes effect
// at the next build only.
module smallest_factor_sieve_factorizer_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [sff_pkg::VAL_W-1:0] cfg_data,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic [15:0]               s_axis_tdata,  // value[11:0], zeros
	input  wire logic [0:0]                s_axis_tuser,  // command[0]
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// prime[11:0], exponent[15:12], value_is_prime[16], divisor_count[22:17], zeros
	output logic      [23:0]               m_axis_tdata,
	output logic      [1:0]                m_axis_tuser,  // status[1:0]
	output logic                           m_axis_tlast
);
	import sff_pkg::*;

	sff_cmd_t         cmd;
	sff_stat_t        stat;
	sff_state_t       state;
	logic [VAL_W-1:0] prime;
	logic [EXP_W-1:0] exponent;
	logic             value_is_prime;
	logic [DC_W-1:0]  divisor_count;

	assign cfg_ready = 1'b1;

	sff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd),
		.state    (state)
	);

	sff_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_command   (s_axis_tuser[0]),
		.in_value     (s_axis_tdata[VAL_W-1:0]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_prime    (prime),
		.out_exponent (exponent),
		.out_is_prime (value_is_prime),
		.out_divisors (divisor_count),
		.out_status   (m_axis_tuser),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, divisor_count, value_is_prime, exponent, prime};

	// Error results are always single and carry no divisor count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tlast && divisor_count == '0)
		else $error("error result not single or has divisors");

	// A prime value has exactly one factor with exponent one and two divisors.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && value_is_prime |->
			m_axis_tlast && exponent == EXP_W'(1) && divisor_count == DC_W'(2))
		else $error("prime value result malformed");

	// Only one transaction is worked on at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// The divider only finishes while the controller waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> state == ST_FZ_DIV)
		else $error("divider finished outside the divide state");
endmodule
`default_nettype wire

@@ hdl/sff_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module sff_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

@@ hdl/sff_div.sv @@
// Restoring divider producing one quotient bit per cycle.
`default_nettype none
module sff_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [sff_pkg::VAL_W-1:0] dividend,
	input  wire logic [sff_pkg::VAL_W-1:0] divisor,
	output logic                           done,
	output logic      [sff_pkg::VAL_W-1:0] quotient
);
	import sff_pkg::*;

	localparam int CW = $clog2(VAL_W);

	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] quo_q;
	logic [VAL_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VAL_W:0]   rem_sh;
	logic             fits;

	// The partial remainder stays below the divisor, so it always fits in VAL_W bits.
	assign rem_sh = {rem_q, quo_q[VAL_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(VAL_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(VAL_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VAL_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[VAL_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

@@ hdl/sff_datapath.sv @@
// Datapath: factor table, sieve counters, factor list and result register.
`default_nettype none
module sff_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sff_pkg::sff_cmd_t         cmd,
	output sff_pkg::sff_stat_t             stat,
	input  wire logic                      cfg_valid,
	input  wire logic [sff_pkg::VAL_W-1:0] cfg_data,
	input  wire logic                      in_command,
	input  wire logic [sff_pkg::VAL_W-1:0] in_value,
	input  wire logic                      out_ready,
	output logic                           out_valid,
	output logic      [sff_pkg::VAL_W-1:0] out_prime,
	output logic      [sff_pkg::EXP_W-1:0] out_exponent,
	output logic                           out_is_prime,
	output logic      [sff_pkg::DC_W-1:0]  out_divisors,
	output logic      [sff_pkg::ST_W-1:0]  out_status,
	output logic                           out_last
);
	import sff_pkg::*;

	logic [VAL_W-1:0]  sieve_limit_q;
	logic              built_q;
	logic [VAL_W-1:0]  built_limit_q;
	logic [VAL_W-1:0]  lim_q;
	logic [VAL_W-1:0]  clr_q;
	logic [VAL_W-1:0]  i_q;
	logic [SQ_W-1:0]   sq_q;
	logic [VAL_W:0]    j_q;
	logic [VAL_W-1:0]  x_q;
	logic [VAL_W-1:0]  last_p_q;
	logic [VAL_W-1:0]  pr_q [MAX_PRIMES];
	logic [EXP_W-1:0]  ex_q [MAX_PRIMES];
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  k_q;
	logic              ip_q;
	logic [DC_W-1:0]   dc_q;
	logic [ST_W-1:0]   st_q;
	logic              out_valid_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [VAL_W-1:0]  wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  rd_data;
	logic              div_done;
	logic [VAL_W-1:0]  quotient;
	logic [VAL_W:0]    j_sum;
	logic              same_p;
	logic [CNT_W-1:0]  n_prev;
	logic [EXP_W:0]    ex_inc;
	logic [DC_W+EXP_W:0] dc_prod;
	logic              in_ok;

	sff_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sff_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.fz_take),
		.dividend (x_q),
		.divisor  (rd_data),
		.done     (div_done),
		.quotient (quotient)
	);

	// Table port selection: clearing, marking the prime itself, or marking a multiple.
	always_comb begin
		wr_en   = cmd.clr_wr | cmd.i_wr | cmd.j_wr;
		wr_addr = ADDR_W'(clr_q);
		wr_data = '0;
		if (cmd.i_wr) begin
			wr_addr = ADDR_W'(i_q);
			wr_data = i_q;
		end else if (cmd.j_wr) begin
			wr_addr = ADDR_W'(j_q[VAL_W-1:0]);
			wr_data = i_q;
		end
		if (cmd.rd_j) begin
			rd_addr = ADDR_W'(j_q[VAL_W-1:0]);
		end else if (cmd.rd_x) begin
			rd_addr = ADDR_W'(x_q);
		end else begin
			rd_addr = ADDR_W'(i_q);
		end
	end

	assign j_sum   = j_q + {1'b0, i_q};
	assign same_p  = (n_q != '0) && (rd_data == last_p_q);
	assign n_prev  = n_q - CNT_W'(1);
	assign ex_inc  = {1'b0, ex_q[k_q]} + (EXP_W+1)'(1);
	assign dc_prod = dc_q * ex_inc;
	assign in_ok   = built_q && (in_value >= VAL_W'(2)) && (in_value <= built_limit_q);

	always_comb begin
		stat.in_build  = in_command == CMD_BUILD;
		stat.in_simple = !in_ok;
		stat.lim_small = lim_q < VAL_W'(2);
		stat.clr_last  = clr_q == lim_q;
		stat.rd_zero   = rd_data == '0;
		stat.sq_in     = sq_q <= SQ_W'(lim_q);
		stat.i_last    = i_q == lim_q;
		stat.j_over    = j_sum > {1'b0, lim_q};
		stat.fz_stop   = (rd_data < VAL_W'(2)) ||
			(!same_p && (n_q == CNT_W'(MAX_PRIMES)));
		stat.div_done  = div_done;
		stat.x_more    = quotient > VAL_W'(1);
		stat.k_last    = (k_q + CNT_W'(1)) >= n_q;
		stat.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sieve_limit_q <= VAL_W'(TABLE_SIZE - 1);
			built_q       <= 1'b0;
			built_limit_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sieve_limit_q <= cfg_data;
			end
			if (cmd.build_done) begin
				built_q       <= 1'b1;
				built_limit_q <= lim_q;
			end
			if (cmd.emit_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lim_q    <= sieve_limit_q;
			clr_q    <= VAL_W'(2);
			i_q      <= VAL_W'(2);
			sq_q     <= SQ_W'(4);
			x_q      <= in_value;
			last_p_q <= '0;
			k_q      <= '0;
			ip_q     <= 1'b0;
			pr_q[0]  <= '0;
			ex_q[0]  <= '0;
			if (in_command == CMD_FACTOR && in_ok) begin
				n_q  <= '0;
				dc_q <= DC_W'(1);
				st_q <= STAT_OK;
			end else begin
				n_q <= CNT_W'(1);
				if (in_command == CMD_BUILD) begin
					dc_q <= '0;
					st_q <= STAT_OK;
				end else if (!built_q) begin
					dc_q <= '0;
					st_q <= STAT_NOTBUILT;
				end else if (in_value == VAL_W'(1) && built_limit_q != '0) begin
					dc_q <= DC_W'(1);
					st_q <= STAT_OK;
				end else begin
					dc_q <= '0;
					st_q <= STAT_RANGE;
				end
			end
		end
		if (cmd.clr_wr) begin
			clr_q <= clr_q + VAL_W'(1);
		end
		if (cmd.i_next) begin
			// (i+1)^2 = i^2 + 2i + 1
			sq_q <= sq_q + SQ_W'({i_q, 1'b1});
			i_q  <= i_q + VAL_W'(1);
		end
		if (cmd.in_start) begin
			j_q <= sq_q[VAL_W:0];
		end else if (cmd.j_next) begin
			j_q <= j_sum;
		end
		if (cmd.build_done) begin
			n_q     <= CNT_W'(1);
			k_q     <= '0;
			pr_q[0] <= '0;
			ex_q[0] <= '0;
			ip_q    <= 1'b0;
			dc_q    <= '0;
			st_q    <= STAT_OK;
		end
		if (cmd.fz_take) begin
			if (n_q == '0) begin
				ip_q <= rd_data == x_q;
			end
			if (same_p) begin
				ex_q[n_prev] <= ex_q[n_prev] + EXP_W'(1);
			end else begin
				pr_q[n_q] <= rd_data;
				ex_q[n_q] <= EXP_W'(1);
				n_q       <= n_q + CNT_W'(1);
			end
			last_p_q <= rd_data;
		end
		if (cmd.x_load) begin
			x_q <= quotient;
		end
		if (cmd.dc_step) begin
			dc_q <= dc_prod[DC_W-1:0];
			k_q  <= stat.k_last ? '0 : k_q + CNT_W'(1);
		end
		if (cmd.emit_step) begin
			out_prime    <= pr_q[k_q];
			out_exponent <= ex_q[k_q];
			out_is_prime <= ip_q;
			out_divisors <= dc_q;
			out_status   <= st_q;
			out_last     <= stat.k_last;
			k_q          <= k_q + CNT_W'(1);
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

@@ hdl/sff_ctrl.sv @@
// Controller state machine sequencing build, factorization and result output.
`default_nettype none
module sff_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sff_pkg::sff_stat_t stat,
	output sff_pkg::sff_cmd_t       cmd,
	output sff_pkg::sff_state_t     state
);
	import sff_pkg::*;

	sff_state_t state_q;
	sff_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.in_build) begin
						state_d = ST_CLR;
					end else if (stat.in_simple) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_FZ_RD;
					end
				end
			end
			ST_CLR: begin
				if (stat.lim_small) begin
					state_d = ST_EMIT;
				end else if (stat.clr_last) begin
					state_d = ST_SV_RD;
				end
			end
			ST_SV_RD:  state_d = ST_SV_CHK;
			ST_SV_CHK: begin
				if (stat.rd_zero && stat.sq_in) begin
					state_d = ST_IN_RD;
				end else if (stat.i_last) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SV_RD;
				end
			end
			ST_IN_RD:  state_d = ST_IN_CHK;
			ST_IN_CHK: begin
				if (!stat.j_over) begin
					state_d = ST_IN_RD;
				end else if (stat.i_last) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SV_RD;
				end
			end
			ST_FZ_RD:  state_d = ST_FZ_CHK;
			ST_FZ_CHK: state_d = stat.fz_stop ? ST_DC : ST_FZ_DIV;
			ST_FZ_DIV: begin
				if (stat.div_done) begin
					state_d = stat.x_more ? ST_FZ_RD : ST_DC;
				end
			end
			ST_DC: begin
				if (stat.k_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free && stat.k_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_CLR: begin
				cmd.clr_wr     = !stat.lim_small;
				cmd.build_done = stat.lim_small;
			end
			ST_SV_CHK: begin
				cmd.i_wr       = stat.rd_zero;
				cmd.in_start   = stat.rd_zero && stat.sq_in;
				cmd.i_next     = !(stat.rd_zero && stat.sq_in) && !stat.i_last;
				cmd.build_done = !(stat.rd_zero && stat.sq_in) && stat.i_last;
			end
			ST_IN_RD: cmd.rd_j = 1'b1;
			ST_IN_CHK: begin
				cmd.j_wr       = stat.rd_zero;
				cmd.j_next     = !stat.j_over;
				cmd.i_next     = stat.j_over && !stat.i_last;
				cmd.build_done = stat.j_over && stat.i_last;
			end
			ST_FZ_RD:  cmd.rd_x = 1'b1;
			ST_FZ_CHK: cmd.fz_take = !stat.fz_stop;
			ST_FZ_DIV: cmd.x_load = stat.div_done;
			ST_DC:     cmd.dc_step = 1'b1;
			ST_EMIT:   cmd.emit_step = stat.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign state = state_q;
endmodule
`default_nettype wire

@@ bench/sff_checker.sv @@
// Checker that predicts and compares the factorizer results seen on the stream ports.
`timescale 1ns / 100ps
module sff_checker (
	input  wire logic        clk,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [11:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,
	input  wire logic [0:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [23:0] m_axis_tdata,
	input  wire logic [1:0]  m_axis_tuser,
	input  wire logic        m_axis_tlast,
	output int               fail_count,
	output int               factor_backlog,
	output int               results_seen
);
	import sff_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] prime;
		logic [EXP_W-1:0] exponent;
		logic             prime_flag;
		logic [DC_W-1:0]  divisors;
		logic [ST_W-1:0]  status;
		logic             last;
	} factor_rec_t;

	factor_rec_t      factor_q[$];
	logic [VAL_W-1:0] spf_table [TABLE_SIZE];
	logic             table_ready = 1'b0;
	logic [VAL_W-1:0] covered_limit = '0;
	logic [VAL_W-1:0] next_limit = 12'd4095;

	initial begin
		fail_count = 0;
		results_seen = 0;
		factor_backlog = 0;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic enqueue(input factor_rec_t r);
		factor_q.insert(factor_q.size(), r);
	endtask

	function automatic factor_rec_t mk(input int p, input int e, input logic ip, input int dc,
			input logic [ST_W-1:0] st, input logic lst);
		factor_rec_t r;
		r.prime = p[VAL_W-1:0];
		r.exponent = e[EXP_W-1:0];
		r.prime_flag = ip;
		r.divisors = dc[DC_W-1:0];
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	task automatic sieve_build();
		int lim;
		lim = next_limit;
		if (lim > TABLE_SIZE - 1)
			lim = TABLE_SIZE - 1;
		for (int i = 0; i < TABLE_SIZE; i++)
			spf_table[i] = '0;
		for (int i = 2; i <= lim; i++) begin
			if (spf_table[i] == 0) begin
				spf_table[i] = i[VAL_W-1:0];
				for (int j = i * i; j <= lim; j += i)
					if (spf_table[j] == 0)
						spf_table[j] = i[VAL_W-1:0];
			end
		end
		covered_limit = lim[VAL_W-1:0];
		table_ready = 1'b1;
		enqueue(mk(0, 0, 1'b0, 0, STAT_OK, 1'b1));
	endtask

	task automatic factorize_value(input int v);
		int primes[7];
		int exps[7];
		int n, x, p, dc;
		logic ip;
		n = 0;
		if (!table_ready) begin
			enqueue(mk(0, 0, 1'b0, 0, STAT_NOTBUILT, 1'b1));
		end else if (v == 0 || v > covered_limit) begin
			enqueue(mk(0, 0, 1'b0, 0, STAT_RANGE, 1'b1));
		end else if (v == 1) begin
			enqueue(mk(0, 0, 1'b0, 1, STAT_OK, 1'b1));
		end else begin
			ip = (spf_table[v] == v);
			x = v;
			while (x > 1) begin
				p = spf_table[x];
				if (n > 0 && primes[n-1] == p) begin
					exps[n-1]++;
				end else begin
					primes[n] = p;
					exps[n] = 1;
					n++;
				end
				x = x / p;
			end
			dc = 1;
			for (int k = 0; k < n; k++)
				dc *= exps[k] + 1;
			for (int k = 0; k < n; k++)
				enqueue(mk(primes[k], exps[k], ip, dc, STAT_OK, k == n - 1));
		end
	endtask

	always @(posedge clk) begin
		factor_rec_t want;
		if (cfg_valid && cfg_ready)
			next_limit = cfg_data;
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (factor_q.size() == 0) begin
				report($sformatf("unexpected result tdata=%h", m_axis_tdata));
			end else begin
				want = factor_q.pop_front();
				if (m_axis_tdata[11:0] != want.prime)
					report($sformatf("prime %0d, want %0d", m_axis_tdata[11:0], want.prime));
				if (m_axis_tdata[15:12] != want.exponent)
					report($sformatf("exponent %0d, want %0d", m_axis_tdata[15:12],
						want.exponent));
				if (m_axis_tdata[16] != want.prime_flag)
					report($sformatf("value_is_prime %0b, want %0b", m_axis_tdata[16],
						want.prime_flag));
				if (m_axis_tdata[22:17] != want.divisors)
					report($sformatf("divisor_count %0d, want %0d", m_axis_tdata[22:17],
						want.divisors));
				if (m_axis_tuser != want.status)
					report($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
				if (m_axis_tlast != want.last)
					report($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
			end
		end
		// The prediction is queued after the compare so a same-edge result is not confused.
		if (s_axis_tvalid && s_axis_tready) begin
			if (s_axis_tuser[0] == CMD_BUILD)
				sieve_build();
			else
				factorize_value(s_axis_tdata[11:0]);
		end
		factor_backlog = factor_q.size();
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the testbench: clock, reset, stimulus, stalls, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
	import sff_pkg::*;

	localparam int STALL_LIMIT = 100000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [11:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int  fail_count, factor_backlog, results_seen;
	int  items_sent = 0;
	int  builds_sent = 0;
	int  quiet_cycles = 0;
	int  out_hold = 0;
	bit  calm = 1'b0;
	int  lim;

	always #5 clk = ~clk;

	smallest_factor_sieve_factorizer_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	sff_checker chk (
		.clk(clk), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count), .factor_backlog(factor_backlog),
		.results_seen(results_seen)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	// The result side is held off for whole gaps so that long stalls also occur.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_hold <= 0;
		end else if (out_hold > 0) begin
			m_axis_tready <= 1'b0;
			out_hold <= out_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			out_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(input logic cmd, input int val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, val[11:0]};
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		items_sent++;
		if (cmd == CMD_BUILD)
			builds_sent++;
	endtask

	// Let every expected result drain before the limit register is touched.
	task automatic settle();
		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		while (factor_backlog != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_limit(input int v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v[11:0];
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_value(input int bound, output int v);
		int r;
		r = $urandom_range(99);
		if (r < 75)
			v = $urandom_range(bound, 2);
		else if (r < 85)
			v = $urandom_range(1, 0);
		else
			v = $urandom_range(4095);
	endtask

	initial begin
		int v;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries before any build.
		send(CMD_FACTOR, 5);
		send(CMD_FACTOR, 0);
		send(CMD_FACTOR, 4095);

		set_limit(2);
		send(CMD_BUILD, 4095);
		send(CMD_FACTOR, 1);
		send(CMD_FACTOR, 2);
		send(CMD_FACTOR, 3);
		send(CMD_FACTOR, 0);

		set_limit(4095);
		send(CMD_BUILD, 0);
		send(CMD_FACTOR, 4095);
		send(CMD_FACTOR, 2048);
		send(CMD_FACTOR, 2310);
		send(CMD_FACTOR, 4093);
		send(CMD_FACTOR, 3840);
		send(CMD_FACTOR, 4094);
		send(CMD_FACTOR, 1);
		send(CMD_FACTOR, 2);
		send(CMD_FACTOR, 3003);

		// A new limit must not matter until the next build.
		set_limit(100);
		send(CMD_FACTOR, 200);
		send(CMD_BUILD, 200);
		send(CMD_FACTOR, 200);
		send(CMD_FACTOR, 100);
		send(CMD_FACTOR, 97);

		for (int phase = 0; phase < 5; phase++) begin
			calm = (phase == 2);
			lim = (phase == 4) ? 4095 : (phase == 1) ? 2 : $urandom_range(400, 3);
			set_limit(lim);
			send(CMD_BUILD, $urandom_range(4095));
			for (int n = 0; n < 52; n++) begin
				random_value(lim, v);
				if ($urandom_range(99) < 4 && lim < 1000)
					send(CMD_BUILD, v);
				else
					send(CMD_FACTOR, v);
			end
		end
		calm = 1'b0;

		settle();
		repeat (200) @(posedge clk);
		$display("sent %0d items (%0d builds) over several sieve limits, checked %0d results",
			items_sent, builds_sent, results_seen);
		if (fail_count == 0 && factor_backlog == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results outstanding", fail_count, factor_backlog);
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sff_pkg.sv
hdl/sff_ram.sv
hdl/sff_div.sv
hdl/sff_datapath.sv
hdl/sff_ctrl.sv
hdl/smallest_factor_sieve_factorizer_core.sv
bench/sff_checker.sv
bench/tb_top.sv
